@@ rtl/gpe_pkg.sv @@
// Shared types and constants of the Gaussian profile evaluator.
// Holds the beat structs, register indexes and fixed-point constants.
// No dependencies.
`default_nettype none

package gpe_pkg;

  // Field and register widths
  localparam int FIELD_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_SCALE = 2'd2;

  // Register reset values
  localparam logic [FIELD_W-1:0] AMPLITUDE_RST   = 32'h0001_0000;
  localparam logic [FIELD_W-1:0] CENTER_RST      = 32'h0000_0000;
  localparam logic [FIELD_W-1:0] WIDTH_SCALE_RST = 32'h0080_0000;

  // Exponent argument t, unsigned Q7.32, saturated at 64.0
  localparam int            T_W   = 39;
  localparam logic [T_W-1:0] T_SAT = 39'h40_0000_0000;

  // Range reduction t = k*ln2 + r
  localparam int                K_W         = 7;
  localparam int                FRAC_W      = 56;
  localparam logic [FRAC_W-1:0] LN2_Q56     = 56'hB1_7217_F7D1_CF7A;
  localparam logic [16:0]       INV_LN2_Q16 = 17'd94548;

  // Series accumulator, Q1.56
  localparam int               ACC_W        = 57;
  localparam logic [ACC_W-1:0] ONE_Q56      = 57'h100_0000_0000_0000;
  localparam int               SERIES_TERMS = 16;
  localparam int               STEP_STAGES  = 5;

  // Split multiplier
  localparam int MUL_W     = 57;
  localparam int MUL_SPLIT = 28;
  localparam int PROD_W    = 2 * MUL_W;

  // Input beat
  typedef struct packed {
    logic signed [FIELD_W-1:0] sample;
    logic                      last_sample;
  } gpe_in_t;

  // Result beat
  typedef struct packed {
    logic signed [FIELD_W-1:0] profile_value;
    logic                      last_value;
  } gpe_out_t;

  // Data that rides along the series pipeline
  typedef struct packed {
    logic              last;
    logic [K_W-1:0]    k;
    logic [FRAC_W-1:0] r;
  } gpe_side_t;

endpackage

`default_nettype wire

@@ rtl/gpe_wide_mul.sv @@
// 57 x 57 bit unsigned multiplier, split into four partial products.
// Two register stages: partial products, then their sum. Uses gpe_pkg.
`default_nettype none

module gpe_wide_mul
  import gpe_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  in_a,
  input  logic [MUL_W-1:0]  in_b,
  output logic [PROD_W-1:0] out_prod
);

  localparam int HI_W = MUL_W - MUL_SPLIT;

  logic [HI_W-1:0]           a_hi, b_hi;
  logic [MUL_SPLIT-1:0]      a_lo, b_lo;
  logic [2*HI_W-1:0]         pp_hh_nxt, pp_hh_r;
  logic [HI_W+MUL_SPLIT-1:0] pp_hl_nxt, pp_hl_r;
  logic [HI_W+MUL_SPLIT-1:0] pp_lh_nxt, pp_lh_r;
  logic [2*MUL_SPLIT-1:0]    pp_ll_nxt, pp_ll_r;
  logic [PROD_W-1:0]         prod_nxt, prod_r;

  assign a_hi = in_a[MUL_W-1:MUL_SPLIT];
  assign a_lo = in_a[MUL_SPLIT-1:0];
  assign b_hi = in_b[MUL_W-1:MUL_SPLIT];
  assign b_lo = in_b[MUL_SPLIT-1:0];

  // Partial products
  always_comb begin
    pp_hh_nxt = a_hi * b_hi;
    pp_hl_nxt = a_hi * b_lo;
    pp_lh_nxt = a_lo * b_hi;
    pp_ll_nxt = a_lo * b_lo;
  end

  always_ff @(posedge clk) begin
    pp_hh_r <= pp_hh_nxt;
    pp_hl_r <= pp_hl_nxt;
    pp_lh_r <= pp_lh_nxt;
    pp_ll_r <= pp_ll_nxt;
  end

  // Align and sum
  always_comb begin
    prod_nxt = (PROD_W'(pp_hh_r) << (2 * MUL_SPLIT))
             + ((PROD_W'(pp_hl_r) + PROD_W'(pp_lh_r)) << MUL_SPLIT)
             + PROD_W'(pp_ll_r);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign out_prod = prod_r;

endmodule

`default_nettype wire

@@ rtl/gpe_series_step.sv @@
// One term of the exp(-r) series: acc' = 1 - floor(floor(r*acc)/N).
// Five register stages; uses gpe_pkg and two gpe_wide_mul instances.
`default_nettype none

module gpe_series_step
  import gpe_pkg::*;
#(
  parameter int N = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  gpe_side_t        in_side,
  input  logic [ACC_W-1:0] in_acc,
  output logic             out_valid,
  output gpe_side_t        out_side,
  output logic [ACC_W-1:0] out_acc
);

  // Exact division by N: floor(P/N) = (P * RECIP) >> (56 + SHIFT_L) for P < 2^56
  localparam int          SHIFT_L    = $clog2(N);
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << (FRAC_W + SHIFT_L)) + 64'(N) - 64'd1) / 64'(N);
  localparam logic [MUL_W-1:0] RECIP = RECIP_FULL[MUL_W-1:0];

  logic [PROD_W-1:0]      prod_ra;
  logic [PROD_W-1:0]      prod_div;
  logic [PROD_W-1:0]      quot_full;
  logic [FRAC_W-1:0]      quot;
  logic [ACC_W-1:0]       acc_nxt, acc_r;
  logic [STEP_STAGES-1:0] valid_pipe_r;
  gpe_side_t              side_pipe_r [STEP_STAGES];

  // r * acc, then keep the Q0.56 part
  gpe_wide_mul u_mul_ra (
    .clk      (clk),
    .in_a     ({1'b0, in_side.r}),
    .in_b     (in_acc),
    .out_prod (prod_ra)
  );

  // divide by N through the reciprocal
  gpe_wide_mul u_mul_div (
    .clk      (clk),
    .in_a     ({1'b0, prod_ra[2*FRAC_W-1:FRAC_W]}),
    .in_b     (RECIP),
    .out_prod (prod_div)
  );

  always_comb begin
    quot_full = prod_div >> (FRAC_W + SHIFT_L);
    quot      = quot_full[FRAC_W-1:0];
    acc_nxt   = ONE_Q56 - {1'b0, quot};
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // side data follows the arithmetic
  always_ff @(posedge clk) begin
    side_pipe_r[0] <= in_side;
    for (int i = 1; i < STEP_STAGES; i++) begin
      side_pipe_r[i] <= side_pipe_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_pipe_r <= '0;
    end else begin
      valid_pipe_r <= {valid_pipe_r[STEP_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = valid_pipe_r[STEP_STAGES-1];
  assign out_side  = side_pipe_r[STEP_STAGES-1];
  assign out_acc   = acc_r;

endmodule

`default_nettype wire

@@ rtl/gaussian_profile_eval_core.sv @@
// Gaussian profile evaluator: amplitude * exp(-(x - center)^2 * width_scale), Q16.16.
// Throughput: one sample per cycle, every cycle; busy stays low, nothing stalls.
// Depth: 91 register stages between a taken start and its out_valid.
// The depth is set by the 16-term exp series, five stages per term (two split multiplies).
// Reset (synchronous, rst_n low) empties the pipeline and restores the register defaults.
// Uses gpe_pkg, gpe_series_step and gpe_wide_mul.
`default_nettype none

module gaussian_profile_eval_core
  import gpe_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 start,
  output logic                 busy,
  input  gpe_in_t              in_item,
  // result channel
  output logic                 out_valid,
  output gpe_out_t             out_item,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_wdata
);

  localparam int DW           = (DATA_WIDTH > FIELD_W) ? FIELD_W : DATA_WIDTH;
  localparam int FRONT_STAGES = 6;
  localparam int TAIL_STAGES  = 4;

  // sign-extend the low DW bits of a Q16.16 word
  function automatic logic signed [FIELD_W:0] sext_dw(input logic [FIELD_W-1:0] v);
    logic signed [FIELD_W-1:0] tmp;
    tmp = $signed(v << (FIELD_W - DW)) >>> (FIELD_W - DW);
    return {tmp[FIELD_W-1], tmp};
  endfunction

  logic                      accept;
  logic [FIELD_W-1:0]        amplitude_r, center_r, width_scale_r;
  logic [FIELD_W-1:0]        amp_abs_r;
  logic                      amp_neg_r;
  logic signed [FIELD_W:0]   amp_ext;
  logic signed [FIELD_W-1:0] amp_sext;

  logic [FRONT_STAGES-1:0]   front_valid_r, front_last_r;
  logic signed [FIELD_W:0]   diff;
  logic [FIELD_W-1:0]        dist_nxt, dist_r;
  logic [2*FIELD_W-1:0]      dsq_nxt, dsq_r;
  logic [2*FIELD_W-1:0]      p_hi, p_lo;
  logic                      sat_hi_r;
  logic [29:0]               p_hi_r;
  logic [39:0]               p_lo_r;
  logic [40:0]               targ_sum;
  logic [T_W-1:0]            targ_nxt, targ_r, targ5_r;
  logic [39:0]               k_prod;
  logic [K_W-1:0]            k_est_r, k_est6_r;
  logic [62:0]               big_t, k_ln2;
  logic [ACC_W-1:0]          rem0_nxt, rem0_r;
  logic                      rem_ge;
  logic [ACC_W-1:0]          rem_adj;
  gpe_side_t                 side_nxt, side_r;
  logic                      side_valid_r;

  logic                      chain_valid [SERIES_TERMS+1];
  gpe_side_t                 chain_side  [SERIES_TERMS+1];
  logic [ACC_W-1:0]          chain_acc   [SERIES_TERMS+1];

  logic [TAIL_STAGES-1:0]    tail_valid_r, tail_last_r;
  logic [ACC_W-1:0]          e_round;
  logic [FIELD_W:0]          e32_r;
  logic [K_W-1:0]            tail_k1_r, tail_k2_r;
  logic [2*FIELD_W-1:0]      mprod_nxt, mprod_r;
  logic [2*FIELD_W-1:0]      msum_nxt, msum_r;
  logic                      underflow_r;
  logic [4:0]                shamt_r;
  logic [FIELD_W-1:0]        mag;
  logic [FIELD_W-1:0]        res_nxt, res_r;

  // no stall source: every start is taken
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r   <= AMPLITUDE_RST;
      center_r      <= CENTER_RST;
      width_scale_r <= WIDTH_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AMPLITUDE:   amplitude_r   <= cfg_wdata;
        CFG_CENTER:      center_r      <= cfg_wdata;
        CFG_WIDTH_SCALE: width_scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // amplitude magnitude and sign, tracked from the register
  assign amp_ext  = sext_dw(amplitude_r);
  assign amp_sext = amp_ext[FIELD_W-1:0];

  always_ff @(posedge clk) begin
    amp_neg_r <= amp_sext[FIELD_W-1];
    amp_abs_r <= amp_sext[FIELD_W-1] ? (FIELD_W'(0) - amp_sext) : amp_sext;
  end

  // ---------------- front-end control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= '0;
    end else begin
      front_valid_r <= {front_valid_r[FRONT_STAGES-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    front_last_r <= {front_last_r[FRONT_STAGES-2:0], in_item.last_sample};
  end

  // S1: distance to center
  always_comb begin
    diff     = sext_dw(in_item.sample) - sext_dw(center_r);
    dist_nxt = diff[FIELD_W] ? FIELD_W'(-diff) : diff[FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
  end

  // S2: squared distance, Q32.32
  assign dsq_nxt = dist_r * dist_r;

  always_ff @(posedge clk) begin
    dsq_r <= dsq_nxt;
  end

  // S3: scale both halves
  always_comb begin
    p_hi = dsq_r[2*FIELD_W-1:FIELD_W] * width_scale_r;
    p_lo = dsq_r[FIELD_W-1:0] * width_scale_r;
  end

  always_ff @(posedge clk) begin
    sat_hi_r <= |p_hi[2*FIELD_W-1:30];
    p_hi_r   <= p_hi[29:0];
    p_lo_r   <= p_lo[63:24];
  end

  // S4: exponent argument, saturated at 64.0
  always_comb begin
    targ_sum = {3'b000, p_hi_r, 8'h00} + {1'b0, p_lo_r};
    if (sat_hi_r || (targ_sum >= 41'(T_SAT))) begin
      targ_nxt = T_SAT;
    end else begin
      targ_nxt = targ_sum[T_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    targ_r <= targ_nxt;
  end

  // S5: quotient estimate t/ln2, low by at most one
  assign k_prod = targ_r[T_W-1:16] * INV_LN2_Q16;

  always_ff @(posedge clk) begin
    k_est_r <= k_prod[38:32];
    targ5_r <= targ_r;
  end

  // S6: remainder against the estimate
  always_comb begin
    big_t    = {targ5_r, 24'h000000};
    k_ln2    = k_est_r * LN2_Q56;
    rem0_nxt = ACC_W'(big_t - k_ln2);
  end

  always_ff @(posedge clk) begin
    rem0_r   <= rem0_nxt;
    k_est6_r <= k_est_r;
  end

  // S7: one correction step gives k and r
  always_comb begin
    rem_ge        = rem0_r >= {1'b0, LN2_Q56};
    rem_adj       = rem_ge ? (rem0_r - {1'b0, LN2_Q56}) : rem0_r;
    side_nxt.last = front_last_r[FRONT_STAGES-1];
    side_nxt.k    = k_est6_r + K_W'(rem_ge);
    side_nxt.r    = rem_adj[FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    side_r <= side_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_valid_r <= 1'b0;
    end else begin
      side_valid_r <= front_valid_r[FRONT_STAGES-1];
    end
  end

  // ---------------- exp(-r) series, highest term first ----------------
  assign chain_valid[0] = side_valid_r;
  assign chain_side[0]  = side_r;
  assign chain_acc[0]   = ONE_Q56;

  for (genvar i = 0; i < SERIES_TERMS; i++) begin : g_term
    gpe_series_step #(
      .N (SERIES_TERMS - i)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[i]),
      .in_side   (chain_side[i]),
      .in_acc    (chain_acc[i]),
      .out_valid (chain_valid[i+1]),
      .out_side  (chain_side[i+1]),
      .out_acc   (chain_acc[i+1])
    );
  end

  // ---------------- tail: scale by 2^-k and amplitude ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_valid_r <= '0;
    end else begin
      tail_valid_r <= {tail_valid_r[TAIL_STAGES-2:0], chain_valid[SERIES_TERMS]};
    end
  end

  always_ff @(posedge clk) begin
    tail_last_r <= {tail_last_r[TAIL_STAGES-2:0], chain_side[SERIES_TERMS].last};
  end

  // F1: round series to Q1.32
  assign e_round = chain_acc[SERIES_TERMS] + ACC_W'(24'h80_0000);

  always_ff @(posedge clk) begin
    e32_r     <= e_round[ACC_W-1:24];
    tail_k1_r <= chain_side[SERIES_TERMS].k;
  end

  // F2: amplitude magnitude times exp(-r)
  assign mprod_nxt = amp_abs_r * e32_r;

  always_ff @(posedge clk) begin
    mprod_r   <= mprod_nxt;
    tail_k2_r <= tail_k1_r;
  end

  // F3: add half an LSB of the final shift
  assign msum_nxt = mprod_r + ((2*FIELD_W)'(1) << (31 + int'(tail_k2_r[4:0])));

  always_ff @(posedge clk) begin
    msum_r      <= msum_nxt;
    underflow_r <= |tail_k2_r[K_W-1:5];
    shamt_r     <= tail_k2_r[4:0];
  end

  // F4: shift by 32 + k, apply sign; zero when k is 32 or more
  always_comb begin
    mag = msum_r[2*FIELD_W-1:FIELD_W] >> shamt_r;
    if (underflow_r) begin
      res_nxt = '0;
    end else if (amp_neg_r) begin
      res_nxt = FIELD_W'(0) - mag;
    end else begin
      res_nxt = mag;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid              = tail_valid_r[TAIL_STAGES-1];
  assign out_item.profile_value = res_r;
  assign out_item.last_value    = tail_last_r[TAIL_STAGES-1];

endmodule

`default_nettype wire
